// ----- rtl/sosw_pkg.sv -----
// ----------------------------------------------------------------------------
// sosw_pkg
// Shared types and constants of the seat occupancy servo sweeper.
// ----------------------------------------------------------------------------
package sosw_pkg;

    // Request codes carried by the request type field.
    localparam logic [1:0] REQ_EDGE = 2'd0;
    localparam logic [1:0] REQ_OVERCAPTURE = 2'd1;
    localparam logic [1:0] REQ_TICK = 2'd2;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_THRESHOLD = 3'd0;
    localparam logic [2:0] REG_FLUSH_DELAY = 3'd1;
    localparam logic [2:0] REG_INTER_SWEEP = 3'd2;
    localparam logic [2:0] REG_SWEEP_COUNT = 3'd3;
    localparam logic [2:0] REG_MAX_ANGLE = 3'd4;
    localparam logic [2:0] REG_STEP_DEG = 3'd5;
    localparam logic [2:0] REG_CAPTURE_TOP = 3'd6;

    localparam int AddrWidth = 5;

    // Reset values of the registers.
    localparam logic [15:0] RST_THRESHOLD = 16'd1000;
    localparam logic [7:0] RST_FLUSH_DELAY = 8'd50;
    localparam logic [7:0] RST_INTER_SWEEP = 8'd100;
    localparam logic [3:0] RST_SWEEP_COUNT = 4'd2;
    localparam logic [7:0] RST_MAX_ANGLE = 8'd65;
    localparam logic [5:0] RST_STEP_DEG = 6'd4;
    localparam logic [15:0] RST_CAPTURE_TOP = 16'hFFFF;

    // Pulse mapping: 1000 + a*1000/180 = 1000 + floor(a*50/9).
    localparam logic [7:0] ANGLE_LIMIT = 8'd180;
    localparam logic [5:0] PULSE_SCALE = 6'd50;
    localparam logic [12:0] RECIP_NINE = 13'd7282; // ceil(2^16 / 9)
    localparam int RECIP_SHIFT = 16;
    localparam logic [10:0] PULSE_BASE = 11'd1000;

    typedef struct packed {
        logic [15:0] threshold;
        logic [7:0]  flush_delay;
        logic [7:0]  inter_sweep;
        logic [3:0]  sweep_count;
        logic [7:0]  max_angle;
        logic [5:0]  step_deg;
        logic [15:0] capture_top;
    } t_cfg;

    // State after the current item, as shown in a result beat.
    typedef struct packed {
        logic       red;
        logic       blue;
        logic       sweep;
        logic [7:0] angle;
    } t_status;

endpackage

// ----- rtl/sosw_cfg.sv -----
// ----------------------------------------------------------------------------
// sosw_cfg
// APB-style configuration register file.
// ----------------------------------------------------------------------------
module sosw_cfg
    import sosw_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [AddrWidth-1:0] paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output t_cfg                 o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign idx    = paddr[AddrWidth-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold   <= RST_THRESHOLD;
            r_cfg.flush_delay <= RST_FLUSH_DELAY;
            r_cfg.inter_sweep <= RST_INTER_SWEEP;
            r_cfg.sweep_count <= RST_SWEEP_COUNT;
            r_cfg.max_angle   <= RST_MAX_ANGLE;
            r_cfg.step_deg    <= RST_STEP_DEG;
            r_cfg.capture_top <= RST_CAPTURE_TOP;
        end else if (wr_en) begin
            unique case (idx)
                REG_THRESHOLD:   r_cfg.threshold   <= pwdata[15:0];
                REG_FLUSH_DELAY: r_cfg.flush_delay <= pwdata[7:0];
                REG_INTER_SWEEP: r_cfg.inter_sweep <= pwdata[7:0];
                REG_SWEEP_COUNT: r_cfg.sweep_count <= pwdata[3:0];
                REG_MAX_ANGLE:   r_cfg.max_angle   <= pwdata[7:0];
                REG_STEP_DEG:    r_cfg.step_deg    <= pwdata[5:0];
                REG_CAPTURE_TOP: r_cfg.capture_top <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_THRESHOLD:   prdata = {16'd0, r_cfg.threshold};
            REG_FLUSH_DELAY: prdata = {24'd0, r_cfg.flush_delay};
            REG_INTER_SWEEP: prdata = {24'd0, r_cfg.inter_sweep};
            REG_SWEEP_COUNT: prdata = {28'd0, r_cfg.sweep_count};
            REG_MAX_ANGLE:   prdata = {24'd0, r_cfg.max_angle};
            REG_STEP_DEG:    prdata = {26'd0, r_cfg.step_deg};
            REG_CAPTURE_TOP: prdata = {16'd0, r_cfg.capture_top};
            default:         prdata = 32'd0;
        endcase
    end

endmodule

// ----- rtl/sosw_core.sv -----
// ----------------------------------------------------------------------------
// sosw_core
// Sit tracking and sweep sequencing state, updated once per item.
// ----------------------------------------------------------------------------
module sosw_core
    import sosw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_fire,
    input  logic [1:0]  i_req_type,
    input  logic [15:0] i_capture_time,
    input  logic        i_pin_level,
    input  t_cfg        i_cfg,
    output t_status     o_next
);

    logic        r_sitting,    n_sitting;
    logic [15:0] r_sit_start,  n_sit_start;
    logic [7:0]  r_angle,      n_angle;
    logic        r_down,       n_down;
    logic        r_sweep,      n_sweep;
    logic        r_top,        n_top;
    logic [7:0]  r_delay,      n_delay;
    logic [3:0]  r_sweeps,     n_sweeps;
    logic        r_red,        n_red;
    logic        r_blue,       n_blue;

    logic [17:0] wrap_sum;
    logic [18:0] elapsed;
    logic        long_sit;
    logic [8:0]  up_sum;

    // Sit length: a direct difference, or one wrap of the capture timer.
    // A wrapped length can go negative, which still counts as a long sit.
    always_comb begin
        wrap_sum = {2'b00, i_cfg.capture_top} + 18'd1 + {2'b00, i_capture_time};
        if (i_capture_time >= r_sit_start) begin
            elapsed = {3'b000, i_capture_time - r_sit_start};
        end else begin
            elapsed = {1'b0, wrap_sum} - {3'b000, r_sit_start};
        end
        long_sit = elapsed[18] || (elapsed[17:0] >= {2'b00, i_cfg.threshold});
    end

    assign up_sum = {1'b0, r_angle} + {3'b000, i_cfg.step_deg};

    always_comb begin
        n_sitting   = r_sitting;
        n_sit_start = r_sit_start;
        n_angle     = r_angle;
        n_down      = r_down;
        n_sweep     = r_sweep;
        n_top       = r_top;
        n_delay     = r_delay;
        n_sweeps    = r_sweeps;
        n_red       = r_red;
        n_blue      = r_blue;
        unique case (i_req_type)
            REQ_EDGE: begin
                if (!i_pin_level) begin
                    if (!r_sitting) begin
                        n_sitting   = 1'b1;
                        n_sit_start = i_capture_time;
                        n_red       = 1'b0;
                        n_blue      = 1'b0;
                        n_sweep     = 1'b0;
                        n_top       = 1'b0;
                        n_delay     = 8'd0;
                        n_sweeps    = 4'd0;
                    end
                end else if (r_sitting) begin
                    n_sitting = 1'b0;
                    n_red     = 1'b1;
                    n_sweep   = 1'b0;
                    n_top     = 1'b0;
                    if (long_sit) begin
                        n_blue   = 1'b1;
                        n_angle  = 8'd0;
                        n_down   = 1'b0;
                        n_delay  = i_cfg.flush_delay;
                        n_sweeps = i_cfg.sweep_count;
                    end else begin
                        n_blue   = 1'b0;
                        n_delay  = 8'd0;
                        n_sweeps = 4'd0;
                    end
                end
            end
            REQ_OVERCAPTURE: begin
                n_sitting = 1'b0;
                n_blue    = 1'b0;
                n_red     = 1'b1;
                n_sweep   = 1'b0;
                n_top     = 1'b0;
                n_delay   = 8'd0;
                n_sweeps  = 4'd0;
            end
            REQ_TICK: begin
                // Countdown to the next sweep; the first move happens on the
                // same tick that starts the sweep.
                if (!r_sweep && (r_delay != 8'd0)) begin
                    n_delay = r_delay - 8'd1;
                    if ((r_delay == 8'd1) && (r_sweeps != 4'd0)) begin
                        n_angle  = 8'd0;
                        n_down   = 1'b0;
                        n_top    = 1'b0;
                        n_sweep  = 1'b1;
                        n_sweeps = r_sweeps - 4'd1;
                    end
                end
                if (n_sweep) begin
                    if (!n_down) begin
                        if ((n_sweep && !r_sweep ? {3'b000, i_cfg.step_deg}
                                                 : up_sum) >= {1'b0, i_cfg.max_angle}) begin
                            n_angle = i_cfg.max_angle;
                            n_down  = 1'b1;
                            n_top   = 1'b1;
                        end else begin
                            n_angle = n_sweep && !r_sweep ? {2'b00, i_cfg.step_deg}
                                                          : up_sum[7:0];
                        end
                    end else if (n_angle <= {2'b00, i_cfg.step_deg}) begin
                        n_angle = 8'd0;
                        if (n_top) begin
                            n_sweep = 1'b0;
                            if (n_sweeps != 4'd0) begin
                                n_down  = 1'b0;
                                n_top   = 1'b0;
                                n_delay = i_cfg.inter_sweep;
                            end
                        end else begin
                            n_down = 1'b0;
                        end
                    end else begin
                        n_angle = n_angle - {2'b00, i_cfg.step_deg};
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sitting   <= 1'b0;
            r_sit_start <= 16'd0;
            r_angle     <= 8'd0;
            r_down      <= 1'b0;
            r_sweep     <= 1'b0;
            r_top       <= 1'b0;
            r_delay     <= 8'd0;
            r_sweeps    <= 4'd0;
            r_red       <= 1'b0;
            r_blue      <= 1'b0;
        end else if (i_fire) begin
            r_sitting   <= n_sitting;
            r_sit_start <= n_sit_start;
            r_angle     <= n_angle;
            r_down      <= n_down;
            r_sweep     <= n_sweep;
            r_top       <= n_top;
            r_delay     <= n_delay;
            r_sweeps    <= n_sweeps;
            r_red       <= n_red;
            r_blue      <= n_blue;
        end
    end

    assign o_next.red   = n_red;
    assign o_next.blue  = n_blue;
    assign o_next.sweep = n_sweep;
    assign o_next.angle = n_angle;

endmodule

// ----- rtl/sosw_pulse.sv -----
// ----------------------------------------------------------------------------
// sosw_pulse
// Maps a servo angle to its pulse width in microseconds.
// ----------------------------------------------------------------------------
module sosw_pulse
    import sosw_pkg::*;
(
    input  logic [7:0]  i_angle,
    input  logic [7:0]  i_max_angle,
    output logic [10:0] o_pulse
);

    logic [7:0]  a_max;
    logic [7:0]  a_clamp;
    logic [13:0] scaled;
    logic [26:0] prod;

    // The quotient by nine comes from a reciprocal multiply; the error stays
    // below one unit for all products up to 180*50.
    always_comb begin
        a_max   = (i_angle > i_max_angle) ? i_max_angle : i_angle;
        a_clamp = (a_max > ANGLE_LIMIT) ? ANGLE_LIMIT : a_max;
        scaled  = 14'(a_clamp) * 14'(PULSE_SCALE);
        prod    = 27'(scaled) * 27'(RECIP_NINE);
        o_pulse = PULSE_BASE + 11'(prod >> RECIP_SHIFT);
    end

endmodule

// ----- rtl/seat_occupancy_servo_sweeper_core.sv -----
// ----------------------------------------------------------------------------
// seat_occupancy_servo_sweeper_core
// Seat sensor sit timer with a delayed, repeating servo sweep sequencer.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Beat contents
//  -------   ---------  -------------------  ---------------------------------
//  request   in         i_valid / o_ready    req_type, capture_time, pin_level
//  result    out        o_valid / i_ready    red_led, blue_led, servo_pulse,
//                                            sweep_active
//  config    in         psel/penable/pready  seven registers at 4*index
//
// A request beat lands in an input register; from there the state update and
// pulse mapping run combinationally into the result register, which drives
// the result port. A held beat moves on only while the result register is
// empty or its beat is being taken. One beat is accepted every cycle while
// the result side keeps up. A stall on the result side holds the result
// register, then the input register; o_ready drops only when both are full.
// Reset is synchronous and active low; it restores the register defaults and
// clears all sit and sweep state.
//
module seat_occupancy_servo_sweeper_core
    import sosw_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Request channel
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [1:0]           i_req_type,
    input  logic [15:0]          i_capture_time,
    input  logic                 i_pin_level,
    // Result channel
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_red_led,
    output logic                 o_blue_led,
    output logic [10:0]          o_servo_pulse,
    output logic                 o_sweep_active,
    // Configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [AddrWidth-1:0] paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    t_cfg        cfg;
    t_status     next_status;
    logic [10:0] next_pulse;
    logic        advance;

    // Input register.
    logic        r_in_valid;
    logic [1:0]  r_in_req;
    logic [15:0] r_in_time;
    logic        r_in_level;

    // Result register.
    logic        r_out_valid;
    logic        r_out_red;
    logic        r_out_blue;
    logic [10:0] r_out_pulse;
    logic        r_out_sweep;

    // The held beat moves on whenever the result register is empty or its
    // beat is being taken this cycle.
    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    sosw_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    sosw_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (advance),
        .i_req_type     (r_in_req),
        .i_capture_time (r_in_time),
        .i_pin_level    (r_in_level),
        .i_cfg          (cfg),
        .o_next         (next_status)
    );

    sosw_pulse u_pulse (
        .i_angle     (next_status.angle),
        .i_max_angle (cfg.max_angle),
        .o_pulse     (next_pulse)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_req   <= i_req_type;
            r_in_time  <= i_capture_time;
            r_in_level <= i_pin_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_red   <= next_status.red;
            r_out_blue  <= next_status.blue;
            r_out_pulse <= next_pulse;
            r_out_sweep <= next_status.sweep;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_red_led      = r_out_red;
    assign o_blue_led     = r_out_blue;
    assign o_servo_pulse  = r_out_pulse;
    assign o_sweep_active = r_out_sweep;

endmodule

// ----- tb/sv/sosw_result_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sosw_result_checker
// Watches the request, result and configuration ports of the seat occupancy
// servo sweeper, predicts every result beat and compares it field by field.
// ----------------------------------------------------------------------------
module sosw_result_checker
    import sosw_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic                 o_ready,
    input  logic [1:0]           i_req_type,
    input  logic [15:0]          i_capture_time,
    input  logic                 i_pin_level,
    input  logic                 o_valid,
    input  logic                 i_ready,
    input  logic                 o_red_led,
    input  logic                 o_blue_led,
    input  logic [10:0]          o_servo_pulse,
    input  logic                 o_sweep_active,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [AddrWidth-1:0] paddr,
    input  logic [31:0]          pwdata,
    input  logic                 pready,
    output int                   o_mismatches,
    output int                   o_outstanding
);

    localparam int PulseSpanUs = 1000;

    typedef struct packed {
        logic        red;
        logic        blue;
        logic [10:0] pulse;
        logic        sweep;
    } t_result;

    // Register copy and seat/sweep state of the predictor.
    t_cfg        cfg;
    logic        seated;
    logic [15:0] sit_stamp;
    logic [7:0]  arm_angle;
    logic        descending;
    logic        sweeping;
    logic        top_reached;
    logic [7:0]  delay_ticks;
    logic [3:0]  sweeps_to_go;
    logic        red_lit;
    logic        blue_lit;

    t_result     pending_results[$];
    int          mismatch_total = 0;

    assign o_mismatches = mismatch_total;

    function automatic void restore_defaults();
        cfg.threshold   = RST_THRESHOLD;
        cfg.flush_delay = RST_FLUSH_DELAY;
        cfg.inter_sweep = RST_INTER_SWEEP;
        cfg.sweep_count = RST_SWEEP_COUNT;
        cfg.max_angle   = RST_MAX_ANGLE;
        cfg.step_deg    = RST_STEP_DEG;
        cfg.capture_top = RST_CAPTURE_TOP;
        seated       = 1'b0;
        sit_stamp    = '0;
        arm_angle    = '0;
        descending   = 1'b0;
        sweeping     = 1'b0;
        top_reached  = 1'b0;
        delay_ticks  = '0;
        sweeps_to_go = '0;
        red_lit      = 1'b0;
        blue_lit     = 1'b0;
    endfunction

    // Stops any armed or running sweep sequence; the arm keeps its position.
    function automatic void drop_sweep();
        sweeping     = 1'b0;
        top_reached  = 1'b0;
        delay_ticks  = '0;
        sweeps_to_go = '0;
    endfunction

    function automatic void take_edge(input logic [15:0] stamp, input logic level);
        int sat_ms;
        if (!level) begin
            if (!seated) begin
                seated    = 1'b1;
                sit_stamp = stamp;
                red_lit   = 1'b0;
                blue_lit  = 1'b0;
                drop_sweep();
            end
        end else if (seated) begin
            seated = 1'b0;
            // One timer wrap is allowed for; a start stamp above the wrap
            // point gives a negative length, which counts as a real sit.
            if (stamp >= sit_stamp)
                sat_ms = int'(stamp) - int'(sit_stamp);
            else
                sat_ms = int'(cfg.capture_top) + 1 + int'(stamp) - int'(sit_stamp);
            red_lit = 1'b1;
            if (sat_ms < 0 || sat_ms >= int'(cfg.threshold)) begin
                blue_lit     = 1'b1;
                arm_angle    = '0;
                descending   = 1'b0;
                top_reached  = 1'b0;
                sweeping     = 1'b0;
                delay_ticks  = cfg.flush_delay;
                sweeps_to_go = cfg.sweep_count;
            end else begin
                blue_lit = 1'b0;
                drop_sweep();
            end
        end
    endfunction

    function automatic void take_tick();
        int next_angle;
        if (!sweeping && delay_ticks != 0) begin
            delay_ticks = delay_ticks - 1'b1;
            if (delay_ticks == 0 && sweeps_to_go != 0) begin
                arm_angle    = '0;
                descending   = 1'b0;
                top_reached  = 1'b0;
                sweeping     = 1'b1;
                sweeps_to_go = sweeps_to_go - 1'b1;
            end
        end
        if (sweeping) begin
            if (!descending) begin
                next_angle = int'(arm_angle) + int'(cfg.step_deg);
                if (next_angle >= int'(cfg.max_angle)) begin
                    arm_angle   = cfg.max_angle;
                    descending  = 1'b1;
                    top_reached = 1'b1;
                end else begin
                    arm_angle = 8'(next_angle);
                end
            end else if (arm_angle <= cfg.step_deg) begin
                arm_angle = '0;
                if (top_reached) begin
                    // Back at rest after a full up-and-down pass.
                    sweeping = 1'b0;
                    if (sweeps_to_go != 0) begin
                        descending  = 1'b0;
                        top_reached = 1'b0;
                        delay_ticks = cfg.inter_sweep;
                    end
                end else begin
                    descending = 1'b0;
                end
            end else begin
                arm_angle = arm_angle - cfg.step_deg;
            end
        end
    endfunction

    function automatic logic [10:0] pulse_width_us();
        int deg;
        deg = int'(arm_angle);
        if (deg > int'(cfg.max_angle))
            deg = int'(cfg.max_angle);
        if (deg > int'(ANGLE_LIMIT))
            deg = int'(ANGLE_LIMIT);
        return 11'(deg * PulseSpanUs / int'(ANGLE_LIMIT) + int'(PULSE_BASE));
    endfunction

    function automatic t_result predict_beat(input logic [1:0] req,
                                             input logic [15:0] stamp,
                                             input logic level);
        t_result res;
        case (req)
            REQ_EDGE: begin
                take_edge(stamp, level);
            end
            REQ_OVERCAPTURE: begin
                seated   = 1'b0;
                blue_lit = 1'b0;
                red_lit  = 1'b1;
                drop_sweep();
            end
            REQ_TICK: begin
                take_tick();
            end
            default: begin
            end
        endcase
        res.red   = red_lit;
        res.blue  = blue_lit;
        res.pulse = pulse_width_us();
        res.sweep = sweeping;
        return res;
    endfunction

    function automatic void compare_field(input string label,
                                          input logic [15:0] want,
                                          input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, label, want, got);
            mismatch_total++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            restore_defaults();
            pending_results.delete();
            o_outstanding <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[AddrWidth-1:2])
                    REG_THRESHOLD:   cfg.threshold   = pwdata[15:0];
                    REG_FLUSH_DELAY: cfg.flush_delay = pwdata[7:0];
                    REG_INTER_SWEEP: cfg.inter_sweep = pwdata[7:0];
                    REG_SWEEP_COUNT: cfg.sweep_count = pwdata[3:0];
                    REG_MAX_ANGLE:   cfg.max_angle   = pwdata[7:0];
                    REG_STEP_DEG:    cfg.step_deg    = pwdata[5:0];
                    REG_CAPTURE_TOP: cfg.capture_top = pwdata[15:0];
                    default: begin
                    end
                endcase
            end
            if (i_valid && o_ready)
                pending_results.push_back(predict_beat(i_req_type, i_capture_time,
                                                       i_pin_level));
            if (o_valid && i_ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: result beat with none expected, expected none, actual",
                             $time);
                    $display("    red %0b blue %0b pulse %0d sweep %0b",
                             o_red_led, o_blue_led, o_servo_pulse, o_sweep_active);
                    mismatch_total++;
                end else begin
                    want = pending_results.pop_front();
                    compare_field("red_led", 16'(want.red), 16'(o_red_led));
                    compare_field("blue_led", 16'(want.blue), 16'(o_blue_led));
                    compare_field("servo_pulse", 16'(want.pulse), 16'(o_servo_pulse));
                    compare_field("sweep_active", 16'(want.sweep), 16'(o_sweep_active));
                end
            end
            o_outstanding <= pending_results.size();
        end
    end

endmodule

// ----- tb/sv/tb_seat_occupancy_servo_sweeper_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_seat_occupancy_servo_sweeper_core
// Drives sensor edges, overcapture events and ticks into the sweeper core
// through a bursty sender and a stalling receiver, reprograms the registers
// between phases, and takes the verdict from the result checker.
// ----------------------------------------------------------------------------
module tb_seat_occupancy_servo_sweeper_core;
    import sosw_pkg::*;

    // Request code that the block does not know; it must only echo state.
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;
    // Register index past the last one; writes to it must be ignored.
    localparam logic [2:0] REG_UNUSED = 3'd7;
    localparam logic LEVEL_SIT = 1'b0;
    localparam logic LEVEL_STAND = 1'b1;

    localparam int PhaseCount = 8;
    localparam int PhaseBeats = 230;
    localparam int SpanCap = 320;
    localparam int WatchdogLimit = 4000;
    localparam int EndSettle = 20;

    typedef enum {
        SINK_OPEN,
        SINK_COIN,
        SINK_PERIODIC,
        SINK_SLOW
    } t_sink_mode;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    logic [1:0]           i_req_type;
    logic [15:0]          i_capture_time;
    logic                 i_pin_level;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic                 o_red_led;
    logic                 o_blue_led;
    logic [10:0]          o_servo_pulse;
    logic                 o_sweep_active;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [AddrWidth-1:0] paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    int mismatches;
    int outstanding;

    // Stimulus bookkeeping. The register copies below only shape the
    // stimulus (sit lengths around the threshold, tick runs long enough to
    // play a whole sweep sequence); prediction lives in the checker.
    int beats_sent = 0;
    int phase_start = 0;
    int burst_left = 0;
    int cur_threshold = 1000;
    int cur_flush = 50;
    int cur_inter = 100;
    int cur_count = 2;
    int cur_max_angle = 65;
    int cur_step = 4;
    int cur_top = 65535;

    int         idle_cycles = 0;
    t_sink_mode sink_mode = SINK_OPEN;
    int         sink_left = 0;
    int         sink_phase = 0;

    seat_occupancy_servo_sweeper_core u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_req_type     (i_req_type),
        .i_capture_time (i_capture_time),
        .i_pin_level    (i_pin_level),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_red_led      (o_red_led),
        .o_blue_led     (o_blue_led),
        .o_servo_pulse  (o_servo_pulse),
        .o_sweep_active (o_sweep_active),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    sosw_result_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_req_type     (i_req_type),
        .i_capture_time (i_capture_time),
        .i_pin_level    (i_pin_level),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_red_led      (o_red_led),
        .o_blue_led     (o_blue_led),
        .o_servo_pulse  (o_servo_pulse),
        .o_sweep_active (o_sweep_active),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .o_mismatches   (mismatches),
        .o_outstanding  (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The result side stalls on a pattern of its own. When its current mode has
    // run its random length, it picks a new one: always ready, coin toss, a regular stall
    // one cycle in four, or a slow sink that takes roughly one beat in five.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (sink_left == 0) begin
                sink_mode = t_sink_mode'($urandom_range(0, 3));
                sink_left = $urandom_range(40, 300);
            end else begin
                sink_left--;
            end
            sink_phase++;
            case (sink_mode)
                SINK_OPEN:     i_ready <= 1'b1;
                SINK_COIN:     i_ready <= 1'($urandom_range(0, 1));
                SINK_PERIODIC: i_ready <= (sink_phase % 4) != 3;
                default:       i_ready <= $urandom_range(0, 9) < 2;
            endcase
        end
    end

    // Watchdog: too many cycles in a row without any beat on any port means
    // the block has hung.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Presents one request beat and returns at the edge that accepts it,
    // leaving valid high so that a following beat can go out back to back.
    // Beats go out in bursts of random length; between bursts the sender
    // drops valid for a random gap, and about a quarter of the bursts run on
    // with no gap at all.
    task automatic send_beat(input logic [1:0] req, input logic [15:0] stamp,
                             input logic level);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid        <= 1'b1;
        i_req_type     <= req;
        i_capture_time <= stamp;
        i_pin_level    <= level;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        beats_sent++;
    endtask

    task automatic send_noise();
        send_beat(2'($urandom_range(0, 3)), 16'($urandom), 1'($urandom));
    endtask

    task automatic send_tick();
        // The time and level fields are don't-care on a tick, so they carry
        // random bits to show that the block ignores them.
        send_beat(REQ_TICK, 16'($urandom), 1'($urandom));
    endtask

    // Stops sending and waits until every predicted result has come back.
    // The checker registers its count, so the first sample is taken at the
    // edge after the last acceptance.
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    // APB write. Back-to-back writes keep psel high and drop only penable
    // for the next setup cycle; configure closes the transfer train.
    task automatic write_reg(input logic [2:0] idx, input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
    endtask

    task automatic configure(input int th, input int fd, input int is, input int sc,
                             input int ma, input int sd, input int ct);
        write_reg(REG_THRESHOLD, th);
        write_reg(REG_FLUSH_DELAY, fd);
        write_reg(REG_INTER_SWEEP, is);
        write_reg(REG_SWEEP_COUNT, sc);
        write_reg(REG_MAX_ANGLE, ma);
        write_reg(REG_STEP_DEG, sd);
        write_reg(REG_CAPTURE_TOP, ct);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_threshold = th;
        cur_flush     = fd;
        cur_inter     = is;
        cur_count     = sc;
        cur_max_angle = ma;
        cur_step      = sd;
        cur_top       = ct;
    endtask

    // Rough number of ticks that plays an armed sequence to its end: the
    // flush delay, then for each sweep the climb, the descent and the pause.
    // A zero step never finishes, so the run is simply capped.
    function automatic int sweep_span();
        int half;
        int span;
        if (cur_step == 0)
            return SpanCap;
        half = (cur_max_angle + cur_step - 1) / cur_step + 1;
        span = cur_flush + cur_count * (2 * half + cur_inter) + 4;
        return (span > SpanCap) ? SpanCap : span;
    endfunction

    // One stretch of random stimulus. Most of it is a well-formed visit:
    // sit down, stand up after a length near the threshold (just above, at,
    // just below, or anywhere), then enough ticks to play the sweeps out,
    // with the odd overcapture, fresh edge or unknown request thrown in.
    // The rest is loose noise and plain tick runs.
    task automatic play_session();
        int pick;
        int t_down;
        int t_up;
        int sit_ms;
        int ticks;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            t_down = $urandom_range(0, cur_top);
            case ($urandom_range(0, 3))
                0: sit_ms = cur_threshold + $urandom_range(0, 40);
                1: sit_ms = cur_threshold - $urandom_range(1, 40);
                2: sit_ms = cur_threshold;
                default: sit_ms = $urandom_range(0, cur_top);
            endcase
            if (sit_ms < 0)
                sit_ms = 0;
            t_up = (t_down + sit_ms) % (cur_top + 1);
            send_beat(REQ_EDGE, 16'(t_down), LEVEL_SIT);
            repeat ($urandom_range(0, 2)) send_tick();
            send_beat(REQ_EDGE, 16'(t_up), LEVEL_STAND);
            ticks = ($urandom_range(0, 3) == 0) ? $urandom_range(0, sweep_span())
                                                 : sweep_span();
            // The tick run stops where the phase's share of beats runs out,
            // so the phase does not overshoot it by a whole sequence.
            if (ticks > PhaseBeats - (beats_sent - phase_start))
                ticks = PhaseBeats - (beats_sent - phase_start);
            if (ticks < 0)
                ticks = 0;
            repeat (ticks) begin
                if ($urandom_range(0, 39) == 0)
                    send_noise();
                else
                    send_tick();
            end
        end else if (pick < 85) begin
            send_noise();
        end else begin
            repeat ($urandom_range(1, 20)) send_tick();
        end
    endtask

    initial begin
        // Every input known from time zero, with reset held at the start.
        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_req_type     <= REQ_TICK;
        i_capture_time <= '0;
        i_pin_level    <= LEVEL_STAND;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed beats under the reset settings: idle tick, unknown
        // request, a stand with nobody seated, overcapture, a repeated sit,
        // a sit across the timer wrap one millisecond short, a sit exactly
        // at the threshold, a cancel by overcapture, a cancel by a new sit
        // and a zero-length sit.
        send_tick();
        send_beat(REQ_UNKNOWN, 16'hFFFF, LEVEL_STAND);
        send_beat(REQ_EDGE, 16'h0000, LEVEL_STAND);
        send_beat(REQ_OVERCAPTURE, 16'h0000, LEVEL_SIT);
        send_beat(REQ_EDGE, 16'hFFFF, LEVEL_SIT);
        send_beat(REQ_EDGE, 16'h0000, LEVEL_SIT);
        send_beat(REQ_EDGE, 16'd998, LEVEL_STAND);
        send_beat(REQ_EDGE, 16'd0, LEVEL_SIT);
        send_beat(REQ_EDGE, 16'd1000, LEVEL_STAND);
        send_tick();
        send_beat(REQ_OVERCAPTURE, 16'hFFFF, LEVEL_STAND);
        send_beat(REQ_EDGE, 16'd100, LEVEL_SIT);
        send_beat(REQ_EDGE, 16'hFFFF, LEVEL_STAND);
        send_beat(REQ_EDGE, 16'd5, LEVEL_SIT);
        send_beat(REQ_EDGE, 16'd5, LEVEL_STAND);

        // Phases of random stimulus, each under its own register setting.
        // The block is drained before every reprogramming, which also makes
        // the sender wait for all outstanding results at least once.
        for (int phase = 0; phase < PhaseCount; phase++) begin
            drain();
            case (phase)
                0: configure(300, 3, 2, 3, 40, 7, 999);
                // Zero threshold and zero delays: every sit is real, but no
                // sweep can ever start.
                1: configure(0, 0, 0, 15, 180, 45, 65535);
                // Top threshold, largest step, angle past the pulse clamp.
                2: configure(65535, 1, 1, 15, 255, 63, 65535);
                // Zero step and longest flush delay: a started sweep never
                // moves and only a cancel ends it.
                3: configure(120, 255, 0, 1, 90, 0, 4095);
                // No sweeps armed, smallest nonzero angle and step.
                4: configure(50, 2, 3, 0, 1, 1, 65535);
                // Zero top angle and a timer that wraps at zero.
                5: configure(500, 4, 5, 2, 0, 3, 0);
                6: configure(RST_THRESHOLD, RST_FLUSH_DELAY, RST_INTER_SWEEP,
                             RST_SWEEP_COUNT, RST_MAX_ANGLE, RST_STEP_DEG,
                             RST_CAPTURE_TOP);
                default: begin
                    write_reg(REG_UNUSED, $urandom);
                    configure($urandom_range(0, 65535), $urandom_range(0, 255),
                              $urandom_range(0, 255), $urandom_range(0, 15),
                              $urandom_range(0, 255), $urandom_range(0, 63),
                              $urandom_range(0, 65535));
                end
            endcase
            if (phase == 0) begin
                // A sit that starts beyond the timer top and ends after the
                // wrap measures negative and must count as a real sit; the
                // ticks then start its first sweep.
                send_beat(REQ_EDGE, 16'd2000, LEVEL_SIT);
                send_beat(REQ_EDGE, 16'd5, LEVEL_STAND);
                repeat (5) send_tick();
            end
            phase_start = beats_sent;
            while (beats_sent - phase_start < PhaseBeats) play_session();
        end

        drain();
        repeat (EndSettle) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/sosw_pkg.sv
rtl/sosw_cfg.sv
rtl/sosw_core.sv
rtl/sosw_pulse.sv
rtl/seat_occupancy_servo_sweeper_core.sv
tb/sv/sosw_result_checker.sv
tb/sv/tb_seat_occupancy_servo_sweeper_core.sv
